// ===== rtl/sfa_pkg.sv =====
// Shared types and constants of the saturating fixed-point ALU.
package sfa_pkg;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_GT      = 4'd4,
    OP_LT      = 4'd5,
    OP_GE      = 4'd6,
    OP_LE      = 4'd7,
    OP_EQ      = 4'd8,
    OP_NE      = 4'd9,
    OP_MIN     = 4'd10,
    OP_MAX     = 4'd11,
    OP_INC     = 4'd12,
    OP_DEC     = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT  = 4'd15
  } sfa_op_e;

  typedef enum logic {
    REG_MAX_INT = 1'b0,
    REG_MIN_INT = 1'b1
  } sfa_reg_e;

  localparam logic [22:0]        MaxIntReset = 23'h7FFFFF;
  localparam logic signed [23:0] MinIntReset = 24'sh800000;
  localparam logic signed [63:0] Int32Max    = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Int32Min    = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic signed [63:0] pre;
    logic               is_div;
    logic               sat_en;
    logic               cmp;
    logic               dz;
    logic               div_neg;
    logic               a_pos;
    logic               a_neg;
  } sfa_side_t;

endpackage

// ===== rtl/saturating_fixed_point_alu_unit.sv =====
// Top level of the saturating fixed-point ALU pipeline.
//
//  channel | dir | handshake                      | payload
//  s_axis  | in  | s_axis_tvalid_i/s_axis_tready_o | tdata a,b; tuser opcode
//  m_axis  | out | m_axis_tvalid_o/m_axis_tready_i | tdata result,cmp,sat,dz
//  cfg     | in  | cfg_valid_i/cfg_ready_o         | cfg_index_i, cfg_data_i
//
// One word per cycle while the output is not stalled; a word passes the front
// stages, the one-bit-per-stage divider chain and the back stages. Every opcode takes the same path.
// Reset clears all valid bits and loads the default limits.
// A stall at the output freezes the whole pipeline; nothing is dropped.
module saturating_fixed_point_alu_unit #(
  parameter int unsigned FracBits = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // operand_a[31:0], operand_b[63:32]
  input  logic [3:0]  s_axis_tuser_i,   // opcode[3:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // result_value[31:0], compare_true[32],
                                        // saturated[33], divide_by_zero[34], zero pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam int unsigned NumW = 33 + FracBits;

  logic               en;
  logic [22:0]        max_int_q;
  logic signed [23:0] min_int_q;

  logic               valid_w [NumW+1];
  sfa_pkg::sfa_side_t side_w  [NumW+1];
  logic [31:0]        rem_w   [NumW+1];
  logic [NumW-1:0]    num_w   [NumW+1];
  logic [31:0]        den_w   [NumW+1];

  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_int_q <= sfa_pkg::MaxIntReset;
      min_int_q <= sfa_pkg::MinIntReset;
    end else if (cfg_valid_i) begin
      case (sfa_pkg::sfa_reg_e'(cfg_index_i))
        sfa_pkg::REG_MAX_INT: max_int_q <= cfg_data_i[22:0];
        sfa_pkg::REG_MIN_INT: min_int_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  sfa_front #(.FracBits(FracBits)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .op_i    (sfa_pkg::sfa_op_e'(s_axis_tuser_i)),
    .a_i     ($signed(s_axis_tdata_i[31:0])),
    .b_i     ($signed(s_axis_tdata_i[63:32])),
    .valid_o (valid_w[0]),
    .side_o  (side_w[0]),
    .num_o   (num_w[0]),
    .den_o   (den_w[0])
  );

  assign rem_w[0] = '0;

  for (genvar i = 0; i < NumW; i++) begin : g_div
    sfa_div_step #(.NumW(NumW)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_w[i]),
      .side_i  (side_w[i]),
      .rem_i   (rem_w[i]),
      .num_i   (num_w[i]),
      .den_i   (den_w[i]),
      .valid_o (valid_w[i+1]),
      .side_o  (side_w[i+1]),
      .rem_o   (rem_w[i+1]),
      .num_o   (num_w[i+1]),
      .den_o   (den_w[i+1])
    );
  end

  sfa_post #(.FracBits(FracBits)) u_post (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (valid_w[NumW]),
    .side_i    (side_w[NumW]),
    .quot_i    (num_w[NumW]),
    .max_int_i (max_int_q),
    .min_int_i (min_int_q),
    .valid_o   (m_axis_tvalid_o),
    .word_o    (m_axis_tdata_o)
  );

endmodule

// ===== rtl/sfa_front.sv =====
// Front stages: operand capture, multiply, per-opcode pre-result and divider setup.
module sfa_front #(
  parameter int unsigned FracBits = 8,
  localparam int unsigned NumW = 33 + FracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  sfa_pkg::sfa_op_e   op_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               valid_o,
  output sfa_pkg::sfa_side_t side_o,
  output logic [NumW-1:0]    num_o,
  output logic [31:0]        den_o
);

  logic               v1_q, v2_q;
  sfa_pkg::sfa_op_e   op1_q;
  logic signed [31:0] a1_q, b1_q;
  logic signed [63:0] prod1_q;

  sfa_pkg::sfa_side_t side_d, side_q;
  logic [NumW-1:0]    num_d, num_q;
  logic [31:0]        den_d, den_q;

  logic signed [63:0] a64, b64, mul_v;
  logic [63:0]        pmag, mr;
  logic [31:0]        amag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q   <= op_i;
      a1_q    <= a_i;
      b1_q    <= b_i;
      prod1_q <= 64'(a_i) * 64'(b_i);
      side_q  <= side_d;
      num_q   <= num_d;
      den_q   <= den_d;
    end
  end

  always_comb begin
    a64   = 64'(a1_q);
    b64   = 64'(b1_q);
    pmag  = prod1_q[63] ? 64'(-prod1_q) : 64'(prod1_q);
    mr    = (pmag + (64'd1 << (FracBits - 1))) >> FracBits;
    mul_v = prod1_q[63] ? -$signed(mr) : $signed(mr);
    amag  = a1_q[31] ? 32'(-a1_q) : 32'(a1_q);

    side_d         = '0;
    side_d.is_div  = (op1_q == sfa_pkg::OP_DIV);
    side_d.dz      = (op1_q == sfa_pkg::OP_DIV) && (b1_q == 32'sd0);
    side_d.div_neg = a1_q[31] ^ b1_q[31];
    side_d.a_pos   = (a1_q > 32'sd0);
    side_d.a_neg   = a1_q[31];
    num_d          = {amag, {(FracBits + 1){1'b0}}};
    den_d          = b1_q[31] ? 32'(-b1_q) : 32'(b1_q);

    case (op1_q)
      sfa_pkg::OP_ADD:      begin side_d.pre = a64 + b64; side_d.sat_en = 1'b1; end
      sfa_pkg::OP_SUB:      begin side_d.pre = a64 - b64; side_d.sat_en = 1'b1; end
      sfa_pkg::OP_MUL:      begin side_d.pre = mul_v;     side_d.sat_en = 1'b1; end
      sfa_pkg::OP_DIV:      side_d.sat_en = 1'b1;
      sfa_pkg::OP_GT:       side_d.cmp = (a1_q > b1_q);
      sfa_pkg::OP_LT:       side_d.cmp = (a1_q < b1_q);
      sfa_pkg::OP_GE:       side_d.cmp = (a1_q >= b1_q);
      sfa_pkg::OP_LE:       side_d.cmp = (a1_q <= b1_q);
      sfa_pkg::OP_EQ:       side_d.cmp = (a1_q == b1_q);
      sfa_pkg::OP_NE:       side_d.cmp = (a1_q != b1_q);
      sfa_pkg::OP_MIN:      side_d.pre = (a1_q < b1_q) ? a64 : b64;
      sfa_pkg::OP_MAX:      side_d.pre = (a1_q > b1_q) ? a64 : b64;
      sfa_pkg::OP_INC:      begin side_d.pre = a64 + 64'sd1; side_d.sat_en = 1'b1; end
      sfa_pkg::OP_DEC:      begin side_d.pre = a64 - 64'sd1; side_d.sat_en = 1'b1; end
      sfa_pkg::OP_FROM_INT: begin side_d.pre = a64 <<< FracBits; side_d.sat_en = 1'b1; end
      default:              side_d.pre = a64 >>> FracBits;
    endcase
  end

  assign valid_o = v2_q;
  assign side_o  = side_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule

// ===== rtl/sfa_div_step.sv =====
// One restoring-division stage: produces one quotient bit per item.
module sfa_div_step #(
  parameter int unsigned NumW = 41
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  sfa_pkg::sfa_side_t side_i,
  input  logic [31:0]        rem_i,
  input  logic [NumW-1:0]    num_i,
  input  logic [31:0]        den_i,
  output logic               valid_o,
  output sfa_pkg::sfa_side_t side_o,
  output logic [31:0]        rem_o,
  output logic [NumW-1:0]    num_o,
  output logic [31:0]        den_o
);

  logic [32:0]        t, diff;
  logic               ge;
  logic               valid_q;
  sfa_pkg::sfa_side_t side_q;
  logic [31:0]        rem_q;
  logic [NumW-1:0]    num_q;
  logic [31:0]        den_q;

  assign t    = {rem_i, num_i[NumW-1]};
  assign diff = t - {1'b0, den_i};
  assign ge   = (t >= {1'b0, den_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      rem_q  <= ge ? diff[31:0] : t[31:0];
      num_q  <= {num_i[NumW-2:0], ge};
      den_q  <= den_i;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule

// ===== rtl/sfa_post.sv =====
// Back stages: quotient rounding and sign, saturation, output register.
module sfa_post #(
  parameter int unsigned FracBits = 8,
  localparam int unsigned NumW = 33 + FracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  sfa_pkg::sfa_side_t side_i,
  input  logic [NumW-1:0]    quot_i,
  input  logic [22:0]        max_int_i,
  input  logic signed [23:0] min_int_i,
  output logic               valid_o,
  output logic [39:0]        word_o
);

  logic [NumW:0]      qr;
  logic signed [63:0] qs, val_d, val_q;
  sfa_pkg::sfa_side_t side_q;
  logic               va_q, vb_q;
  logic signed [63:0] hi_raw, lo_raw, hi, lo, res;
  logic               sat;
  logic [39:0]        word_q;

  always_comb begin
    qr    = ({1'b0, quot_i} + (NumW + 1)'(1)) >> 1;
    qs    = $signed(64'(qr));
    val_d = side_i.is_div ? (side_i.div_neg ? -qs : qs) : side_i.pre;
  end

  always_comb begin
    hi_raw = $signed(64'(max_int_i)) <<< FracBits;
    lo_raw = 64'(min_int_i) <<< FracBits;
    hi     = (hi_raw > sfa_pkg::Int32Max) ? sfa_pkg::Int32Max : hi_raw;
    lo     = (lo_raw < sfa_pkg::Int32Min) ? sfa_pkg::Int32Min : lo_raw;
    res    = val_q;
    sat    = 1'b0;
    if (side_q.dz) begin
      if (side_q.a_pos) begin
        res = hi;
        sat = 1'b1;
      end else if (side_q.a_neg) begin
        res = lo;
        sat = 1'b1;
      end else begin
        res = '0;
      end
    end else if (side_q.sat_en) begin
      if (val_q > hi) begin
        res = hi;
        sat = 1'b1;
      end else if (val_q < lo) begin
        res = lo;
        sat = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q  <= val_d;
      side_q <= side_i;
      word_q <= {5'd0, side_q.dz, sat, side_q.cmp, res[31:0]};
    end
  end

  assign valid_o = vb_q;
  assign word_o  = word_q;

endmodule

// ===== rtl/sfa_checker.sv =====
// Port-level checks of the ALU output stream.
module sfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped under stall");

  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[32] |-> m_axis_tdata_o[31:0] == 32'd0)
    else $error("compare word with nonzero value");

  a_cmp_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[32] |-> !m_axis_tdata_o[33] && !m_axis_tdata_o[34])
    else $error("compare word with arithmetic flags");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[39:35] == 5'd0)
    else $error("pad bits set");

endmodule

bind saturating_fixed_point_alu_unit sfa_checker u_sfa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== test/tb.sv =====
// Testbench for the saturating fixed-point ALU: random and directed words, scoreboard check.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 8;
  localparam int TIMEOUT_CYCLES = 400000;

  typedef struct {
    logic signed [31:0] value;
    logic               cmp;
    logic               sat;
    logic               dz;
  } alu_result_t;

  class alu_scoreboard;
    longint      hi_lim, lo_lim;
    alu_result_t pending[$];
    int          errors;

    function new();
      set_limits(sfa_pkg::MaxIntReset, sfa_pkg::MinIntReset);
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
      if (v < -64'sh80000000) return -64'sh80000000;
      return v;
    endfunction

    function void set_limits(logic [22:0] mx, logic signed [23:0] mn);
      longint mx_l, mn_l;
      mx_l = longint'(mx);
      mn_l = longint'(mn);
      hi_lim = clamp32(mx_l * (64'sd1 << FRAC));
      lo_lim = clamp32(mn_l * (64'sd1 << FRAC));
    endfunction

    function longint clip(longint v, ref logic sat);
      if (v > hi_lim) begin
        sat = 1;
        return hi_lim;
      end
      if (v < lo_lim) begin
        sat = 1;
        return lo_lim;
      end
      return v;
    endfunction

    function longint magn(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function void note_input(sfa_pkg::sfa_op_e op, logic signed [31:0] a32,
                             logic signed [31:0] b32);
      longint a, b, r, p, m;
      logic c, s, z;
      a = a32;
      b = b32;
      r = 0;
      c = 0;
      s = 0;
      z = 0;
      case (op)
        sfa_pkg::OP_ADD: r = clip(a + b, s);
        sfa_pkg::OP_SUB: r = clip(a - b, s);
        sfa_pkg::OP_MUL: begin
          p = a * b;
          m = (magn(p) + (64'sd1 << (FRAC - 1))) >>> FRAC;
          r = clip((p < 0) ? -m : m, s);
        end
        sfa_pkg::OP_DIV: begin
          if (b == 0) begin
            z = 1;
            if (a > 0) begin
              r = hi_lim;
              s = 1;
            end else if (a < 0) begin
              r = lo_lim;
              s = 1;
            end
          end else begin
            m = (2 * (magn(a) << FRAC) + magn(b)) / (2 * magn(b));
            r = clip(((a < 0) != (b < 0)) ? -m : m, s);
          end
        end
        sfa_pkg::OP_GT: c = a > b;
        sfa_pkg::OP_LT: c = a < b;
        sfa_pkg::OP_GE: c = a >= b;
        sfa_pkg::OP_LE: c = a <= b;
        sfa_pkg::OP_EQ: c = a == b;
        sfa_pkg::OP_NE: c = a != b;
        sfa_pkg::OP_MIN: r = (a < b) ? a : b;
        sfa_pkg::OP_MAX: r = (a > b) ? a : b;
        sfa_pkg::OP_INC: r = clip(a + 1, s);
        sfa_pkg::OP_DEC: r = clip(a - 1, s);
        sfa_pkg::OP_FROM_INT: r = clip(a * (64'sd1 << FRAC), s);
        default: r = a >>> FRAC;
      endcase
      pending.push_back('{r[31:0], c, s, z});
    endfunction

    function void check(logic [39:0] d);
      alu_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", d);
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.value || d[32] !== e.cmp || d[33] !== e.sat || d[34] !== e.dz) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp val=%h cmp=%b sat=%b dz=%b, got val=%h cmp=%b sat=%b dz=%b",
                   e.value, e.cmp, e.sat, e.dz, d[31:0], d[32], d[33], d[34]);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid_i = 0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic [3:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 0;
  logic [39:0] m_axis_tdata_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 0;
  logic [23:0] cfg_data_i = '0;

  logic   no_idle = 0;
  int     cycles = 0;
  alu_scoreboard sb = new();

  saturating_fixed_point_alu_unit #(.FracBits(FRAC)) DUT (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      sb.note_input(sfa_pkg::sfa_op_e'(s_axis_tuser_i), s_axis_tdata_i[31:0],
                    s_axis_tdata_i[63:32]);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check(m_axis_tdata_o);
    m_axis_tready_i <= rst_ni && (no_idle || $urandom_range(99) >= 18);
  end

  task automatic send_word(sfa_pkg::sfa_op_e op, logic [31:0] a, logic [31:0] b);
    while (!no_idle && $urandom_range(99) < 18) begin
      s_axis_tvalid_i <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic write_reg(sfa_pkg::sfa_reg_e idx, logic [23:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic set_limits(logic [22:0] mx, logic signed [23:0] mn);
    write_reg(sfa_pkg::REG_MAX_INT, {1'b0, mx});
    write_reg(sfa_pkg::REG_MIN_INT, mn);
    sb.set_limits(mx, mn);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(4000) - 2000;
      2: return ($urandom_range(200) - 100) << FRAC;
      3: return 32'h7FFFFFFF - $urandom_range(3);
      4: return 32'h80000000 + $urandom_range(3);
      default: return ($urandom_range(65535) - 32768) << ($urandom_range(12));
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [31:0] a, b;
    for (int i = 0; i < n; i++) begin
      no_idle <= (i >= n / 3 && i < n / 2);
      a = pick_operand();
      b = ($urandom_range(9) == 0) ? 32'd0 : pick_operand();
      send_word(sfa_pkg::sfa_op_e'($urandom_range(15)), a, b);
    end
    no_idle <= 0;
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: every opcode, operand extremes, rounding ties, divide by zero
    for (int op = 0; op < 16; op++)
      send_word(sfa_pkg::sfa_op_e'(op), 32'h80000000, 32'h7FFFFFFF);
    send_word(sfa_pkg::OP_MUL, 32'd1, 32'd128);
    send_word(sfa_pkg::OP_MUL, 32'hFFFFFFFF, 32'd128);
    send_word(sfa_pkg::OP_DIV, 32'd1, 32'd512);
    send_word(sfa_pkg::OP_DIV, 32'd5, 32'd0);
    send_word(sfa_pkg::OP_DIV, 32'hFFFFFFFB, 32'd0);
    send_word(sfa_pkg::OP_DIV, 32'd0, 32'd0);
    send_word(sfa_pkg::OP_EQ, 32'd7, 32'd7);
    send_word(sfa_pkg::OP_TO_INT, 32'hFFFFFF01, 32'd0);
    drain();

    random_phase(400);
    set_limits(23'd0, 24'sd0);
    random_phase(250);
    set_limits(23'd100, -24'sd100);
    random_phase(300);
    set_limits(23'h7FFFFF, 24'sh800000);
    random_phase(250);
    set_limits(23'($urandom_range(23'h7FFFFF)), 24'(-$urandom_range(24'h7FFFFF)));
    random_phase(300);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
